### rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the stereo point triangulator: operand
// widths, divider lane payload and configuration register indexes.
// ----------------------------------------------------------------------------
package spt_pkg;

  // pixel coordinates, unsigned q12.4
  localparam int unsigned PIX_W   = 16;
  // baseline in micrometres
  localparam int unsigned BASE_W  = 20;
  // divisor magnitude (disparity is at most 65535 counts)
  localparam int unsigned DIV_W   = 16;
  // numerator magnitude: 20 x 16 bit product
  localparam int unsigned NUM_W   = BASE_W + PIX_W;
  // one divider cell per quotient bit
  localparam int unsigned N_CELLS = NUM_W;
  // z, x and y quotients run side by side
  localparam int unsigned LANES   = 3;
  localparam int unsigned COORD_W = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = BASE_W;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd3;

  // lane order inside the divider payload
  localparam int unsigned LANE_Z = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;

  // largest magnitude a result may take, also the infinity marker
  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

  // one long division in flight: partial remainder and the shared
  // numerator / quotient shift word (numerator bits leave at the top,
  // quotient bits enter at the bottom)
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } spt_lane_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic                  zero_disp;
    logic [DIV_W-1:0]      dmag;
    logic [LANES-1:0]      neg;
    spt_lane_t [LANES-1:0] lane;
  } spt_div_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [PIX_W-1:0]  focal;
    logic [BASE_W-1:0] baseline;
    logic [PIX_W-1:0]  center_x;
    logic [PIX_W-1:0]  center_y;
  } spt_cfg_t;

endpackage

### rtl/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front
// Input stage: disparity, signs and magnitudes, the three numerator
// products, registered as the first payload of the divider chain.
// ----------------------------------------------------------------------------
module spt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spt_pkg::spt_cfg_t         cfg_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [spt_pkg::PIX_W-1:0] left_x_i,
  input  logic [spt_pkg::PIX_W-1:0] left_y_i,
  input  logic [spt_pkg::PIX_W-1:0] right_x_i,
  output logic                      valid_o,
  output spt_pkg::spt_div_t         data_o,
  input  logic                      ready_i
);

  logic                        valid_q;
  spt_pkg::spt_div_t           data_q, data_d;

  logic [spt_pkg::PIX_W:0]     disp, off_x, off_y;
  logic [spt_pkg::DIV_W-1:0]   disp_mag;
  logic [spt_pkg::PIX_W-1:0]   off_x_mag, off_y_mag;
  logic [spt_pkg::NUM_W-1:0]   prod_z, prod_x, prod_y;

  // signed differences, 17 bits each
  assign disp  = {1'b0, left_x_i} - {1'b0, right_x_i};
  assign off_x = {1'b0, left_x_i} - {1'b0, cfg_i.center_x};
  assign off_y = {1'b0, left_y_i} - {1'b0, cfg_i.center_y};

  assign disp_mag  = disp[spt_pkg::PIX_W]  ? spt_pkg::DIV_W'(-disp) : disp[spt_pkg::DIV_W-1:0];
  assign off_x_mag = off_x[spt_pkg::PIX_W] ? spt_pkg::PIX_W'(-off_x) : off_x[spt_pkg::PIX_W-1:0];
  assign off_y_mag = off_y[spt_pkg::PIX_W] ? spt_pkg::PIX_W'(-off_y) : off_y[spt_pkg::PIX_W-1:0];

  // 20 x 16 bit magnitude products
  assign prod_z = {{spt_pkg::PIX_W{1'b0}}, cfg_i.baseline}
                * {{spt_pkg::BASE_W{1'b0}}, cfg_i.focal};
  assign prod_x = {{spt_pkg::PIX_W{1'b0}}, cfg_i.baseline}
                * {{spt_pkg::BASE_W{1'b0}}, off_x_mag};
  assign prod_y = {{spt_pkg::PIX_W{1'b0}}, cfg_i.baseline}
                * {{spt_pkg::BASE_W{1'b0}}, off_y_mag};

  // payload for the first divider cell
  always_comb begin
    data_d.zero_disp = (disp == '0);
    data_d.dmag      = disp_mag;
    data_d.neg[spt_pkg::LANE_Z] = disp[spt_pkg::PIX_W];
    data_d.neg[spt_pkg::LANE_X] = disp[spt_pkg::PIX_W] ^ off_x[spt_pkg::PIX_W];
    data_d.neg[spt_pkg::LANE_Y] = disp[spt_pkg::PIX_W] ^ off_y[spt_pkg::PIX_W];
    data_d.lane[spt_pkg::LANE_Z].rem = '0;
    data_d.lane[spt_pkg::LANE_Z].nq  = prod_z;
    data_d.lane[spt_pkg::LANE_X].rem = '0;
    data_d.lane[spt_pkg::LANE_X].nq  = prod_x;
    data_d.lane[spt_pkg::LANE_Y].rem = '0;
    data_d.lane[spt_pkg::LANE_Y].nq  = prod_y;
  end

  // stage moves when empty or when the next cell takes its item
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/spt_div_cell.sv
// ----------------------------------------------------------------------------
// spt_div_cell
// One restoring division step for all three lanes: brings down the next
// numerator bit, compares against the disparity magnitude, subtracts and
// shifts in one quotient bit, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module spt_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  spt_pkg::spt_div_t data_i,
  output logic              valid_o,
  output spt_pkg::spt_div_t data_o,
  input  logic              ready_i
);

  logic                      valid_q;
  spt_pkg::spt_div_t         data_q, data_d;
  logic [spt_pkg::DIV_W:0]   trial [spt_pkg::LANES];
  logic [spt_pkg::LANES-1:0] fits;

  // one quotient bit per lane
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < spt_pkg::LANES; l++) begin
      trial[l] = {data_i.lane[l].rem, data_i.lane[l].nq[spt_pkg::NUM_W-1]};
      fits[l]  = (trial[l] >= {1'b0, data_i.dmag});
      data_d.lane[l].rem = fits[l] ? spt_pkg::DIV_W'(trial[l] - {1'b0, data_i.dmag})
                                   : trial[l][spt_pkg::DIV_W-1:0];
      data_d.lane[l].nq  = {data_i.lane[l].nq[spt_pkg::NUM_W-2:0], fits[l]};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/spt_out_stage.sv
// ----------------------------------------------------------------------------
// spt_out_stage
// Output register: applies signs, saturates the quotients to 31-bit
// magnitude and replaces the result with the infinity marker when the
// disparity was zero.
// ----------------------------------------------------------------------------
module spt_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  spt_pkg::spt_div_t           data_i,
  output logic                        valid_o,
  output logic                        point_valid_o,
  output logic [spt_pkg::COORD_W-1:0] depth_z_o,
  output logic [spt_pkg::COORD_W-1:0] pos_x_o,
  output logic [spt_pkg::COORD_W-1:0] pos_y_o,
  input  logic                        ready_i
);

  logic                        valid_q;
  logic                        point_valid_q;
  logic [spt_pkg::COORD_W-1:0] coord_q [spt_pkg::LANES];
  logic [spt_pkg::COORD_W-1:0] coord_d [spt_pkg::LANES];
  logic [spt_pkg::COORD_W-2:0] mag     [spt_pkg::LANES];

  // saturate, then restore the sign
  always_comb begin
    for (int l = 0; l < spt_pkg::LANES; l++) begin
      mag[l] = (data_i.lane[l].nq[spt_pkg::NUM_W-1:spt_pkg::COORD_W-1] != '0)
             ? spt_pkg::SAT_MAX[spt_pkg::COORD_W-2:0]
             : data_i.lane[l].nq[spt_pkg::COORD_W-2:0];
      if (data_i.zero_disp) begin
        coord_d[l] = spt_pkg::SAT_MAX;
      end else if (data_i.neg[l]) begin
        coord_d[l] = -{1'b0, mag[l]};
      end else begin
        coord_d[l] = {1'b0, mag[l]};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      point_valid_q <= !data_i.zero_disp;
      for (int l = 0; l < spt_pkg::LANES; l++) begin
        coord_q[l] <= coord_d[l];
      end
    end
  end

  assign valid_o       = valid_q;
  assign point_valid_o = point_valid_q;
  assign depth_z_o     = coord_q[spt_pkg::LANE_Z];
  assign pos_x_o       = coord_q[spt_pkg::LANE_X];
  assign pos_y_o       = coord_q[spt_pkg::LANE_Y];

endmodule

### rtl/stereo_point_triangulator_core.sv
// ----------------------------------------------------------------------------
// stereo_point_triangulator_core
// Rectified stereo triangulation: left point and matching right x in,
// 3D point in signed micrometres out.
// ----------------------------------------------------------------------------
// The block accepts one point per clock and delivers one result per clock
// when the output side keeps tready high. From input accept to output
// tvalid an item passes through one input stage (disparity and the three
// 20 x 16 bit products), a row of 36 divider cells that each resolve one
// quotient bit of the depth, x and y quotients at once, and one output
// register that signs and saturates. Every stage holds its item while the
// stage after it is full and stalled, so up to 38 items are in flight and
// empty slots close up under backpressure. Zero disparity gives tuser low
// and all coordinates 0x7fffffff. Configuration writes are always taken
// and act on items accepted after the write.
module stereo_point_triangulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // left_x, left_y, right_x
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // depth_z, pos_x, pos_y
  output logic [0:0]                     m_axis_tuser   // point_valid
);

  spt_pkg::spt_cfg_t cfg_q;

  // configuration registers, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal    <= 16'd8000;
      cfg_q.baseline <= 20'd120000;
      cfg_q.center_x <= 16'd5120;
      cfg_q.center_y <= 16'd3840;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        spt_pkg::REG_FOCAL:    cfg_q.focal    <= cfg_data_i[spt_pkg::PIX_W-1:0];
        spt_pkg::REG_BASELINE: cfg_q.baseline <= cfg_data_i[spt_pkg::BASE_W-1:0];
        spt_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data_i[spt_pkg::PIX_W-1:0];
        spt_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[spt_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // chain links: index 0 is the input stage output, N_CELLS the last cell
  logic              link_valid [spt_pkg::N_CELLS+1];
  logic              link_ready [spt_pkg::N_CELLS+1];
  spt_pkg::spt_div_t link_data  [spt_pkg::N_CELLS+1];

  logic                        point_valid;
  logic [spt_pkg::COORD_W-1:0] depth_z, pos_x, pos_y;

  // input stage
  spt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .left_x_i  (s_axis_tdata[15:0]),
    .left_y_i  (s_axis_tdata[31:16]),
    .right_x_i (s_axis_tdata[47:32]),
    .valid_o   (link_valid[0]),
    .data_o    (link_data[0]),
    .ready_i   (link_ready[0])
  );

  // divider row, one quotient bit per cell, msb first
  for (genvar c = 0; c < spt_pkg::N_CELLS; c++) begin : g_cell
    spt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[c]),
      .ready_o (link_ready[c]),
      .data_i  (link_data[c]),
      .valid_o (link_valid[c+1]),
      .data_o  (link_data[c+1]),
      .ready_i (link_ready[c+1])
    );
  end

  // sign, saturation and output register
  spt_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (link_valid[spt_pkg::N_CELLS]),
    .ready_o       (link_ready[spt_pkg::N_CELLS]),
    .data_i        (link_data[spt_pkg::N_CELLS]),
    .valid_o       (m_axis_tvalid),
    .point_valid_o (point_valid),
    .depth_z_o     (depth_z),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .ready_i       (m_axis_tready)
  );

  assign m_axis_tdata = {pos_y, pos_x, depth_z};
  assign m_axis_tuser = point_valid;

  // zero disparity always carries the infinity marker in every field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0]
      |-> m_axis_tdata == {spt_pkg::SAT_MAX, spt_pkg::SAT_MAX, spt_pkg::SAT_MAX})
    else $error("zero disparity result without infinity marker");

  // saturation stops at -2147483647, the most negative code never appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:0] != 32'h8000_0000
                   && m_axis_tdata[63:32] != 32'h8000_0000
                   && m_axis_tdata[95:64] != 32'h8000_0000)
    else $error("result below negative saturation bound");

  // the partial remainder leaving the last cell stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_valid[spt_pkg::N_CELLS] && !link_data[spt_pkg::N_CELLS].zero_disp
      |-> link_data[spt_pkg::N_CELLS].lane[spt_pkg::LANE_Z].rem
            < link_data[spt_pkg::N_CELLS].dmag
       && link_data[spt_pkg::N_CELLS].lane[spt_pkg::LANE_X].rem
            < link_data[spt_pkg::N_CELLS].dmag
       && link_data[spt_pkg::N_CELLS].lane[spt_pkg::LANE_Y].rem
            < link_data[spt_pkg::N_CELLS].dmag)
    else $error("divider remainder not below divisor");

  // a stalled output register keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_point_triangulator_core. Points are pushed
// through the input stream, each accepted item is triangulated by an
// in-bench predictor under the currently loaded camera registers, and every
// result taken from the output stream is compared field by field in order.
// Covers reset values, register masking and unused indexes, saturation and
// zero-disparity cases, random camera setups under several idle/stall mixes,
// and a long output hold that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import spt_pkg::*;

  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     MAX_PRINTS   = 40;
  localparam longint SAT_LIMIT    = longint'(SAT_MAX);

  typedef struct {
    logic [PIX_W-1:0] left_x;
    logic [PIX_W-1:0] left_y;
    logic [PIX_W-1:0] right_x;
  } point_t;

  typedef struct {
    logic               point_valid;
    logic [COORD_W-1:0] depth_z;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } point3d_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata  = '0;  // left_x, left_y, right_x
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [95:0]           m_axis_tdata;        // depth_z, pos_x, pos_y
  logic [0:0]            m_axis_tuser;        // point_valid

  // camera registers as the predictor sees them
  logic [PIX_W-1:0]  focal_q     = 16'd8000;
  logic [BASE_W-1:0] baseline_um = 20'd120000;
  logic [PIX_W-1:0]  center_x_q  = 16'd5120;
  logic [PIX_W-1:0]  center_y_q  = 16'd3840;

  point3d_t expected_pts[$];
  int       tx_idle_pct  = 0;
  int       rx_stall_pct = 0;
  int       hold_req     = 0;
  int       hold_ack     = 0;
  int       hold_left    = 0;
  int       err_cnt      = 0;

  stereo_point_triangulator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // truncating divide, clamped to the symmetric 32-bit range
  function automatic logic [COORD_W-1:0] sat_quotient(longint num, longint den);
    longint q;
    q = num / den;
    if (q > SAT_LIMIT) q = SAT_LIMIT;
    else if (q < -SAT_LIMIT) q = -SAT_LIMIT;
    return q[COORD_W-1:0];
  endfunction

  function automatic point3d_t triangulate(point_t p);
    point3d_t r;
    longint   disp;
    disp = longint'(p.left_x) - longint'(p.right_x);
    if (disp == 0) begin
      // no disparity: point at infinity
      r.point_valid = 1'b0;
      r.depth_z     = SAT_MAX;
      r.pos_x       = SAT_MAX;
      r.pos_y       = SAT_MAX;
    end else begin
      r.point_valid = 1'b1;
      r.depth_z = sat_quotient(longint'(baseline_um) * longint'(focal_q), disp);
      r.pos_x   = sat_quotient((longint'(p.left_x) - longint'(center_x_q))
                               * longint'(baseline_um), disp);
      r.pos_y   = sat_quotient((longint'(p.left_y) - longint'(center_y_q))
                               * longint'(baseline_um), disp);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [COORD_W-1:0] got,
                               input logic [COORD_W-1:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $time);
  endtask

  // one config write; valid stays up for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FOCAL:    focal_q     = val[PIX_W-1:0];
      REG_BASELINE: baseline_um = val;
      REG_CENTER_X: center_x_q  = val[PIX_W-1:0];
      REG_CENTER_Y: center_y_q  = val[PIX_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers; junk above bit 15 must be masked off
  task automatic load_config(input logic [PIX_W-1:0] focal, input logic [BASE_W-1:0] base,
                             input logic [PIX_W-1:0] cx, input logic [PIX_W-1:0] cy);
    write_reg(REG_FOCAL,    {4'($urandom), focal});
    write_reg(REG_BASELINE, base);
    write_reg(REG_CENTER_X, {4'($urandom), cx});
    write_reg(REG_CENTER_Y, {4'($urandom), cy});
    cfg_valid_i <= 1'b0;
  endtask

  // valid stays up across items unless an idle gap is drawn
  task automatic send_point(input logic [PIX_W-1:0] lx, input logic [PIX_W-1:0] ly,
                            input logic [PIX_W-1:0] rx);
    point_t p;
    p.left_x  = lx;
    p.left_y  = ly;
    p.right_x = rx;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rx, ly, lx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pts.push_back(triangulate(p));
  endtask

  task automatic send_random();
    logic [PIX_W-1:0] lx;
    logic [PIX_W-1:0] rx;
    lx = 16'($urandom);
    case ($urandom_range(3))
      // small disparity of either sign, zero included
      0: rx = lx - 16'($urandom_range(8)) + 16'd4;
      // disparity of 0 to 1023 counts, as in real scenes
      1: rx = lx - 16'($urandom_range(1023));
      default: rx = 16'($urandom);
    endcase
    send_point(lx, 16'($urandom), rx);
  endtask

  // stop offering and wait until every expected item has come back
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_pts.size() != 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned hi);
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_DATA_W'(hi);
      2: return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(hi));
    endcase
  endfunction

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // edge points under the reset camera setup
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_point(16'd5120, 16'd3840, 16'd5120);
    send_point(16'd0,     16'd0,     16'd0);
    send_point(16'hFFFF,  16'hFFFF,  16'hFFFF);
    send_point(16'hFFFF,  16'd0,     16'd0);
    send_point(16'd0,     16'hFFFF,  16'hFFFF);
    send_point(16'd5121,  16'd3840,  16'd5120);
    send_point(16'd0,     16'd0,     16'd1);
    send_point(16'hFFFF,  16'hFFFF,  16'hFFFE);
    send_point(16'hFFFE,  16'd0,     16'hFFFF);
    send_point(16'd7,     16'd3,     16'd4);
    drain_points();
  endtask

  // unused indexes must leave the registers alone
  task automatic test_register_map();
    set_idling(0, 0);
    for (int i = int'(REG_CENTER_Y) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    send_point(16'd9000, 16'd100, 16'd8000);
    send_point(16'd100,  16'd9000, 16'd300);
    drain_points();
  endtask

  // largest and smallest camera values, zero focal and baseline
  task automatic test_saturation();
    set_idling(0, 0);
    load_config(16'hFFFF, 20'hFFFFF, 16'd0, 16'd0);
    send_point(16'd1,    16'hFFFF, 16'd0);
    send_point(16'd0,    16'hFFFF, 16'd1);
    send_point(16'hFFFF, 16'd0,    16'd0);
    send_point(16'd0,    16'd0,    16'hFFFF);
    drain_points();
    load_config(16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'd0, 16'd0, 16'd1);
    send_point(16'd1, 16'd0, 16'd0);
    drain_points();
    // truncation toward zero on tiny quotients
    load_config(16'd1, 20'd1, 16'd0, 16'd0);
    send_point(16'hFFFF, 16'hFFFF, 16'd0);
    send_point(16'd3,    16'd2,    16'd1);
    send_point(16'd0,    16'd3,    16'd2);
    drain_points();
    load_config(16'd0, 20'd0, 16'd5120, 16'd3840);
    send_point(16'd6000, 16'd100, 16'd5000);
    send_point(16'd6000, 16'd100, 16'd6000);
    drain_points();
  endtask

  // random camera setups under each idle and stall mix
  task automatic test_random_phases();
    int mix[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{29, 29}};
    for (int ph = 0; ph < 4; ph++) begin
      load_config(PIX_W'(pick_value(16'hFFFF)), pick_value(20'hFFFFF),
                  PIX_W'(pick_value(16'hFFFF)), PIX_W'(pick_value(16'hFFFF)));
      set_idling(mix[ph][0], mix[ph][1]);
      repeat (220) send_random();
      drain_points();
    end
  endtask

  // long output hold fills the pipeline, then random output stalls
  task automatic test_backpressure();
    load_config(16'd8000, 20'd120000, 16'd5120, 16'd3840);
    set_idling(0, 0);
    hold_req++;
    repeat (120) send_random();
    drain_points();
    set_idling(0, 65);
    repeat (40) send_random();
    drain_points();
  endtask

  // output side: random stalls plus an occasional long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // compare each result with the oldest expected point
  always @(posedge clk_i) begin : check_results
    point3d_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pts.size() == 0) begin
        flag_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_pts.pop_front();
        if (m_axis_tuser[0] !== want.point_valid)
          flag_mismatch("point_valid", COORD_W'(m_axis_tuser), COORD_W'(want.point_valid));
        if (m_axis_tdata[31:0] !== want.depth_z)
          flag_mismatch("depth_z", m_axis_tdata[31:0], want.depth_z);
        if (m_axis_tdata[63:32] !== want.pos_x)
          flag_mismatch("pos_x", m_axis_tdata[63:32], want.pos_x);
        if (m_axis_tdata[95:64] !== want.pos_y)
          flag_mismatch("pos_y", m_axis_tdata[95:64], want.pos_y);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_map();
    test_saturation();
    test_random_phases();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_pts.size() != 0)
      flag_mismatch("results left over", COORD_W'(expected_pts.size()), '0);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
